// ----- rtl/core/dstq_pkg.sv -----
// shared types, codes and defaults for the deadline sorted timer queue
// no dependencies; imported by dstq_ring and deadline_sorted_timer_queue
package dstq_pkg;

    // default sizes
    localparam int DEPTH_DEF      = 16;
    localparam int ID_COUNT_DEF   = 64;
    localparam int TIME_WIDTH_DEF = 32;

    // fixed field widths of the stream items
    localparam int ID_W     = 6;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 40;

    // operation codes (input tuser)
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CANCEL = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    // result kinds (output tuser)
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_FIRED  = 2'd1;
    localparam logic [1:0] KIND_WAIT   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_DUP       = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INSERT,
        S_TICK,
        S_REPORT
    } t_state;

    // per-cycle control of the entry ring
    typedef struct packed {
        logic shift;
        logic wr_en;
        logic wr_cancel;
    } t_ring_ctl;

endpackage

// ----- rtl/core/dstq_ring.sv -----
// entry ring of the timer queue: deadline, id and cancel mark per slot
// entries move one slot toward the head on a shift; one slot can be written
// depends on dstq_pkg
module dstq_ring #(
    parameter int DEPTH      = dstq_pkg::DEPTH_DEF,
    parameter int TIME_WIDTH = dstq_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dstq_pkg::t_ring_ctl           i_ctl,
    input  logic [$clog2(DEPTH)-1:0]      i_wr_pos,
    input  logic [TIME_WIDTH-1:0]         i_wr_deadline,
    input  logic [dstq_pkg::ID_W-1:0]     i_wr_id,
    output logic [TIME_WIDTH-1:0]         o_head_deadline,
    output logic [dstq_pkg::ID_W-1:0]     o_head_id,
    output logic                          o_head_cancel
);
    import dstq_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic [TIME_WIDTH-1:0] r_dl  [DEPTH];
    logic [ID_W-1:0]       r_tid [DEPTH];
    logic [DEPTH-1:0]      r_cxl;

    // one cell per slot: written value wins, else take the neighbor on a shift
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic sel_wr;
        assign sel_wr = i_ctl.wr_en && (i_wr_pos == PW'(k));

        if (k < DEPTH - 1) begin : g_mid
            // payload, no reset
            always_ff @(posedge i_clk) begin
                if (sel_wr) begin
                    r_dl[k]  <= i_wr_deadline;
                    r_tid[k] <= i_wr_id;
                end else if (i_ctl.shift) begin
                    r_dl[k]  <= r_dl[k+1];
                    r_tid[k] <= r_tid[k+1];
                end
            end

            // cancel marks
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cxl[k] <= 1'b0;
                end else if (sel_wr) begin
                    r_cxl[k] <= i_ctl.wr_cancel;
                end else if (i_ctl.shift) begin
                    r_cxl[k] <= r_cxl[k+1];
                end
            end
        end else begin : g_end
            // last slot only takes writes
            always_ff @(posedge i_clk) begin
                if (sel_wr) begin
                    r_dl[k]  <= i_wr_deadline;
                    r_tid[k] <= i_wr_id;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_cxl[k] <= 1'b0;
                end else if (sel_wr) begin
                    r_cxl[k] <= i_ctl.wr_cancel;
                end
            end
        end
    end

    // head slot feeds the shared compare unit
    assign o_head_deadline = r_dl[0];
    assign o_head_id       = r_tid[0];
    assign o_head_cancel   = r_cxl[0];

endmodule

// ----- rtl/core/deadline_sorted_timer_queue.sv -----
// top level of the deadline sorted timer queue: sequencer, shared subtractor
// and output register around the entry ring
// depends on dstq_pkg and dstq_ring
//
// Usage:
//   input items on s_axis: tuser holds the operation (insert, remove, cancel,
//   tick), tdata the task id and a time value (deadline or current time).
//   Result items on m_axis: tuser holds the kind (status, fired, wait), tdata
//   id, wait time and status, tlast marks the final result of an input item.
//   The queue is a ring of DEPTH slots that moves one entry past a single
//   subtract/compare unit per cycle; that ring walk sets the timing.
//   With N entries queued: remove and cancel walk all N once, an accepted
//   insert walks them twice (check pass, then placing pass) and a rejected
//   one once, and a tick walks only the P entries it pops. One item is
//   worked on at a time; s_axis_tready is high only between items.
//   Results wait in one output register; when the receiver stalls, a tick
//   stops before popping the next uncancelled entry until the register is
//   taken. The next item may be accepted while the last result still waits.
//   Reset (synchronous, active low) empties the queue and drops any result
//   in the output register; the block is ready in the cycle after reset.
module deadline_sorted_timer_queue #(
    parameter int DEPTH      = dstq_pkg::DEPTH_DEF,
    parameter int ID_COUNT   = dstq_pkg::ID_COUNT_DEF,
    parameter int TIME_WIDTH = dstq_pkg::TIME_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata: task_id[5:0], time_value[37:6], zero pad[39:38]
    input  logic [dstq_pkg::DATA_W-1:0] s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [1:0]                  s_axis_tuser,
    // result items
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata: fired_id[5:0], wait_time[37:6], status[39:38]
    output logic [dstq_pkg::DATA_W-1:0] m_axis_tdata,
    // tuser: kind[1:0]
    output logic [1:0]                  m_axis_tuser,
    // tlast: last
    output logic                        m_axis_tlast
);
    import dstq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = TIME_WIDTH;

    t_state r_state, n_state;

    // latched item
    logic [1:0]      r_op;
    logic [ID_W-1:0] r_id;
    logic [TW-1:0]   r_time;

    // queue bookkeeping
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_step, n_step;
    logic [CW-1:0] r_less, n_less;
    logic          r_found, n_found;
    logic          r_ins, n_ins;
    logic [1:0]    r_status, n_status;

    // output register
    logic              r_out_valid;
    logic [1:0]        r_out_kind;
    logic [ID_W-1:0]   r_out_id;
    logic [TIME_W-1:0] r_out_wait;
    logic [1:0]        r_out_status;
    logic              r_out_last;

    logic              emit;
    logic [1:0]        emit_kind;
    logic [ID_W-1:0]   emit_id;
    logic [TIME_W-1:0] emit_wait;
    logic [1:0]        emit_status;
    logic              emit_last;

    // ring interface
    t_ring_ctl       ring_ctl;
    logic [PW-1:0]   wr_pos;
    logic [TW-1:0]   wr_dl;
    logic [ID_W-1:0] wr_id;
    logic [TW-1:0]   head_dl;
    logic [ID_W-1:0] head_id;
    logic            head_cancel;

    logic            in_acc;
    logic            out_free;
    logic [1:0]      in_op;
    logic [ID_W-1:0] in_id;
    logic            in_id_bad;
    logic [TW:0]     diff;
    logic            head_lt;
    logic            head_le;
    logic            id_match;
    logic            tick_pop;
    logic [CW-1:0]   cnt_dec;

    dstq_ring #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_ring (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ring_ctl),
        .i_wr_pos        (wr_pos),
        .i_wr_deadline   (wr_dl),
        .i_wr_id         (wr_id),
        .o_head_deadline (head_dl),
        .o_head_id       (head_id),
        .o_head_cancel   (head_cancel)
    );

    // handshakes
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_id         = s_axis_tdata[ID_W-1:0];
    assign in_id_bad     = (int'(in_id) >= ID_COUNT);

    // shared subtract unit: head deadline against the latched time
    assign diff     = {1'b0, head_dl} - {1'b0, r_time};
    assign head_lt  = diff[TW];
    assign head_le  = diff[TW] || (diff[TW-1:0] == '0);
    assign id_match = (head_id == r_id);
    assign tick_pop = (r_cnt != '0) && head_le;
    assign cnt_dec  = r_cnt - CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_TICK) begin
                        n_state = S_TICK;
                    end else if (in_id_bad) begin
                        n_state = S_REPORT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_step == r_total) begin
                    if (r_op == OP_INSERT && !r_found && r_cnt != CW'(DEPTH)) begin
                        n_state = S_INSERT;
                    end else begin
                        n_state = S_REPORT;
                    end
                end
            end
            S_INSERT: begin
                if (r_ins && r_step == r_total) begin
                    n_state = S_REPORT;
                end
            end
            S_TICK: begin
                if (!tick_pop && out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // datapath control and result generation
    always_comb begin
        ring_ctl    = '0;
        wr_pos      = cnt_dec[PW-1:0];
        wr_dl       = head_dl;
        wr_id       = head_id;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_step      = r_step;
        n_less      = r_less;
        n_found     = r_found;
        n_ins       = r_ins;
        n_status    = r_status;
        emit        = 1'b0;
        emit_kind   = KIND_STATUS;
        emit_id     = '0;
        emit_wait   = '0;
        emit_status = ST_OK;
        emit_last   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_total  = r_cnt;
                    n_step   = '0;
                    n_less   = '0;
                    n_found  = 1'b0;
                    n_ins    = 1'b0;
                    n_status = ST_NOT_FOUND;
                end
            end
            S_SCAN: begin
                if (r_step != r_total) begin
                    // rotate one entry past the head, dropping a match on remove or marking it on cancel
                    ring_ctl.shift = 1'b1;
                    n_step         = r_step + CW'(1);
                    if (id_match) begin
                        n_found = 1'b1;
                    end
                    if (r_op == OP_INSERT && head_lt) begin
                        n_less = r_less + CW'(1);
                    end
                    if (r_op == OP_REMOVE && id_match) begin
                        n_cnt = cnt_dec;
                    end else begin
                        ring_ctl.wr_en     = 1'b1;
                        ring_ctl.wr_cancel = head_cancel || (r_op == OP_CANCEL && id_match);
                    end
                end else if (r_op == OP_INSERT) begin
                    // placing pass walks the ring again from the head
                    n_step = '0;
                    if (r_found) begin
                        n_status = ST_DUP;
                    end else if (r_cnt == CW'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_OK;
                    end
                end else begin
                    n_status = r_found ? ST_OK : ST_NOT_FOUND;
                end
            end
            S_INSERT: begin
                if (!r_ins && r_step == r_less) begin
                    // place the new entry behind the earlier deadlines
                    ring_ctl.wr_en     = 1'b1;
                    ring_ctl.wr_cancel = 1'b0;
                    wr_pos             = r_cnt[PW-1:0];
                    wr_dl              = r_time;
                    wr_id              = r_id;
                    n_cnt              = r_cnt + CW'(1);
                    n_ins              = 1'b1;
                end else if (r_step != r_total) begin
                    ring_ctl.shift     = 1'b1;
                    ring_ctl.wr_en     = 1'b1;
                    ring_ctl.wr_cancel = head_cancel;
                    n_step             = r_step + CW'(1);
                end
            end
            S_TICK: begin
                if (tick_pop) begin
                    // pop due entries, firing those not cancelled
                    if (head_cancel) begin
                        ring_ctl.shift = 1'b1;
                        n_cnt          = cnt_dec;
                    end else if (out_free) begin
                        ring_ctl.shift = 1'b1;
                        n_cnt          = cnt_dec;
                        emit           = 1'b1;
                        emit_kind      = KIND_FIRED;
                        emit_id        = head_id;
                    end
                end else if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = KIND_WAIT;
                    emit_wait = (r_cnt != '0) ? TIME_W'(diff[TW-1:0]) : '0;
                    emit_last = 1'b1;
                end
            end
            S_REPORT: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_kind   = KIND_STATUS;
                    emit_id     = r_id;
                    emit_status = r_status;
                    emit_last   = 1'b1;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and sequencer registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= in_op;
            r_id   <= in_id;
            r_time <= TW'(s_axis_tdata[ID_W +: TIME_W]);
        end
        r_total  <= n_total;
        r_step   <= n_step;
        r_less   <= n_less;
        r_found  <= n_found;
        r_ins    <= n_ins;
        r_status <= n_status;
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind   <= emit_kind;
            r_out_id     <= emit_id;
            r_out_wait   <= emit_wait;
            r_out_status <= emit_status;
            r_out_last   <= emit_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_status, r_out_wait, r_out_id};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count above depth");

    a_insert_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |-> (r_cnt == r_total + CW'(r_ins)))
        else $error("insert pass lost or gained entries");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_step <= r_total))
        else $error("scan stepped past the queued entries");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("accepted item started no work");

    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FIRED) |-> !m_axis_tlast)
        else $error("fired item marked as last");

endmodule
